### hw/rtl/vcbe_pkg.sv
// ----------------------------------------------------------------------------
// vcbe_pkg
// Shared constants, command codes and types of the voxel cube buffer engine.
// ----------------------------------------------------------------------------
package vcbe_pkg;

    localparam int CUBE_SIDE   = 8;
    localparam int COORD_W     = 3;
    localparam int BYTE_W      = 8;
    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = 2 * COORD_W;
    localparam int ROW_STRIDE  = 8;
    localparam int CMD_W       = 4;

    localparam logic [BYTE_W-1:0]  BIT_MASK = BYTE_W'((1 << CUBE_SIDE) - 1);
    localparam logic [COORD_W:0]   SIDE_C   = (COORD_W + 1)'(CUBE_SIDE);
    localparam logic [COORD_W-1:0] LAST_C   = COORD_W'(CUBE_SIDE - 1);
    localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(STORE_DEPTH - 1);

    localparam logic [CMD_W-1:0] CMD_FILL   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_INVERT = 4'd1;
    localparam logic [CMD_W-1:0] CMD_XOR    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_XUP    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_YUP    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_ZUP    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_XDN    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_YDN    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_SET    = 4'd8;
    localparam logic [CMD_W-1:0] CMD_GET    = 4'd9;
    localparam logic [CMD_W-1:0] CMD_ZDN    = 4'd10;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [BYTE_W-1:0]  val;
    } t_job;

    typedef struct packed {
        logic               pix_en;
        logic               pix;
    } t_probe;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

endpackage

### hw/rtl/voxel_cube_buffer_engine_top.sv
// ----------------------------------------------------------------------------
// voxel_cube_buffer_engine_top
// 8x8x8 voxel image held in a ring of 64 column cells; each command rotates
// the ring once through the head stage, which rewrites every column.
//
//  port group                      | dir | transfer
//  --------------------------------+-----+------------------------------------
//  start, i_command .. i_data_value| in  | accepted when start && !busy
//  o_valid, o_pixel_out            | out | one-cycle strobe, no backpressure
//
//  A command makes one full turn of the 64-cell column ring.
//  The result strobe follows in the cycle after the turn, with busy low, so
//  the next command can be taken in that same cycle.
//  Reset clears every voxel, the ring control and the strobe.
//  The receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module voxel_cube_buffer_engine_top import vcbe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [COORD_W-1:0] i_x_coord,
    input  logic [COORD_W-1:0] i_y_coord,
    input  logic [COORD_W-1:0] i_z_coord,
    input  logic [BYTE_W-1:0]  i_data_value,
    output logic               o_valid,
    output logic               o_pixel_out
);

    t_state             r_state;
    t_state             n_state;
    logic [IDX_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   n_cnt;
    t_job               r_job;
    t_job               n_job;
    logic               r_pix;
    logic               n_pix;
    logic               r_valid;
    logic               n_valid;
    logic               accept;
    logic               run;
    logic               last;
    logic [BYTE_W-1:0]  ring  [STORE_DEPTH];
    logic [BYTE_W-1:0]  dly   [ROW_STRIDE];
    logic [BYTE_W-1:0]  head_new;
    t_probe             probe;

    assign accept = start && (r_state == S_IDLE);
    assign run    = (r_state == S_RUN);
    assign last   = run && (r_cnt == IDX_LAST);

    // column ring: cell k takes cell k+1, the tail takes the head result
    genvar k;
    generate
        for (k = 0; k < STORE_DEPTH; k++) begin : g_ring
            if (k == STORE_DEPTH - 1) begin : g_tail
                vcbe_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_adv   (run),
                    .i_d     (head_new),
                    .o_q     (ring[k])
                );
            end else begin : g_body
                vcbe_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_adv   (run),
                    .i_d     (ring[k+1]),
                    .o_q     (ring[k])
                );
            end
        end
        // delay line of original columns passed by the head
        for (k = 0; k < ROW_STRIDE; k++) begin : g_dly
            if (k == 0) begin : g_first
                vcbe_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_adv   (run),
                    .i_d     (ring[0]),
                    .o_q     (dly[k])
                );
            end else begin : g_rest
                vcbe_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_adv   (run),
                    .i_d     (dly[k-1]),
                    .o_q     (dly[k])
                );
            end
        end
    endgenerate

    vcbe_head u_head (
        .i_job   (r_job),
        .i_idx   (r_cnt),
        .i_cur   (ring[0]),
        .i_prev1 (dly[0]),
        .i_prev8 (dly[ROW_STRIDE-1]),
        .i_next1 (ring[1]),
        .i_next8 (ring[ROW_STRIDE]),
        .o_new   (head_new),
        .o_probe (probe)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_job   = r_job;
        n_pix   = r_pix;
        n_valid = last;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                    n_pix   = 1'b0;
                    n_job   = '{cmd: i_command, x: i_x_coord, y: i_y_coord,
                                z: i_z_coord, val: i_data_value};
                end
            end
            S_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (probe.pix_en) begin
                    n_pix = probe.pix;
                end
                if (last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
            r_pix   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
            r_pix   <= n_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    assign busy        = run;
    assign o_valid     = r_valid;
    assign o_pixel_out = r_pix;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy && r_cnt == '0))
        else $error("accepted transaction did not start a ring turn");

    a_valid_after_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy) && $past(r_cnt) == IDX_LAST))
        else $error("result strobe without a completed ring turn");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !accept) |=> (!busy && !o_valid))
        else $error("idle block produced activity");

    a_pix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_job.cmd != CMD_GET) |-> !o_pixel_out)
        else $error("pixel set for a non-read transaction");

endmodule

### hw/rtl/vcbe_cell.sv
// ----------------------------------------------------------------------------
// vcbe_cell
// One byte cell of a shift chain; takes its neighbor's byte when advanced.
// ----------------------------------------------------------------------------
module vcbe_cell import vcbe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [BYTE_W-1:0] i_d,
    output logic [BYTE_W-1:0] o_q
);

    logic [BYTE_W-1:0] r_q;
    logic [BYTE_W-1:0] n_q;

    always_comb begin
        n_q = i_adv ? i_d : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

### hw/rtl/vcbe_head.sv
// ----------------------------------------------------------------------------
// vcbe_head
// Operation stage at the head of the column ring: computes the new column
// byte from the passing byte and its ring neighbors.
// ----------------------------------------------------------------------------
module vcbe_head import vcbe_pkg::*; (
    input  t_job              i_job,
    input  logic [IDX_W-1:0]  i_idx,
    input  logic [BYTE_W-1:0] i_cur,
    input  logic [BYTE_W-1:0] i_prev1,
    input  logic [BYTE_W-1:0] i_prev8,
    input  logic [BYTE_W-1:0] i_next1,
    input  logic [BYTE_W-1:0] i_next8,
    output logic [BYTE_W-1:0] o_new,
    output t_probe            o_probe
);

    logic [COORD_W-1:0] tx;
    logic [COORD_W-1:0] ty;
    logic               active;
    logic               in_cube;
    logic               hit;
    logic [BYTE_W-1:0]  bit_sel;
    logic [BYTE_W-1:0]  op_val;

    always_comb begin
        tx      = i_idx[IDX_W-1:COORD_W];
        ty      = i_idx[COORD_W-1:0];
        active  = ({1'b0, tx} < SIDE_C) && ({1'b0, ty} < SIDE_C);
        in_cube = ({1'b0, i_job.x} < SIDE_C) && ({1'b0, i_job.y} < SIDE_C)
                  && ({1'b0, i_job.z} < SIDE_C);
        hit     = in_cube && (tx == i_job.x) && (ty == i_job.y);
        bit_sel = BYTE_W'(1) << i_job.z;
        case (i_job.cmd)
            CMD_FILL:   op_val = i_job.val & BIT_MASK;
            CMD_INVERT: op_val = ~i_cur & BIT_MASK;
            CMD_XOR:    op_val = (i_cur ^ i_job.val) & BIT_MASK;
            CMD_ZUP:    op_val = (i_cur << 1) & BIT_MASK;
            CMD_ZDN:    op_val = (i_cur >> 1) & BIT_MASK;
            CMD_XUP:    op_val = (tx == '0) ? '0 : i_prev8;
            CMD_XDN:    op_val = (tx == LAST_C) ? '0 : i_next8;
            CMD_YUP:    op_val = (ty == '0) ? '0 : i_prev1;
            CMD_YDN:    op_val = (ty == LAST_C) ? '0 : i_next1;
            CMD_SET: begin
                if (hit) begin
                    op_val = (i_job.val != '0) ? (i_cur | bit_sel) : (i_cur & ~bit_sel);
                end else begin
                    op_val = i_cur;
                end
            end
            default:    op_val = i_cur;
        endcase
        o_new          = active ? op_val : i_cur;
        o_probe.pix_en = hit && (i_job.cmd == CMD_GET);
        o_probe.pix    = i_cur[i_job.z];
    end

endmodule
